// File: rtl/mic1_pkg.sv
// Shared types and constants for the MIC-1 microcycle data path.
package mic1_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int CS_DEPTH  = 512;
    localparam int CS_AW     = $clog2(CS_DEPTH);
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int ROW_AW    = MEM_AW - 2;
    localparam int ROWS      = MEM_BYTES / 4;
    localparam int LANES     = 4;

    // Bit positions inside the microinstruction fields.
    localparam int JAM_Z    = 0;
    localparam int JAM_N    = 1;
    localparam int JAM_C    = 2;
    localparam int SFT_SRA1 = 0;
    localparam int SFT_SLL8 = 1;
    localparam int ALU_INC  = 0;
    localparam int ALU_INVA = 1;
    localparam int ALU_ENB  = 2;
    localparam int ALU_ENA  = 3;
    localparam int MEM_FETCH = 0;
    localparam int MEM_READ  = 1;
    localparam int MEM_WRITE = 2;
    localparam int C_MAR = 0;
    localparam int C_MDR = 1;
    localparam int C_PC  = 2;
    localparam int C_SP  = 3;
    localparam int C_LV  = 4;
    localparam int C_CPP = 5;
    localparam int C_TOS = 6;
    localparam int C_OPC = 7;
    localparam int C_H   = 8;

    typedef enum logic [1:0] {
        REQ_CS_WRITE  = 2'd0,
        REQ_MEM_WRITE = 2'd1,
        REQ_RUN       = 2'd2,
        REQ_NOP       = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        B_MDR  = 4'd0,
        B_PC   = 4'd1,
        B_MBR  = 4'd2,
        B_MBRU = 4'd3,
        B_SP   = 4'd4,
        B_LV   = 4'd5,
        B_CPP  = 4'd6,
        B_TOS  = 4'd7,
        B_OPC  = 4'd8
    } bsel_t;

    typedef enum logic [1:0] {
        ALU_OP_AND  = 2'd0,
        ALU_OP_OR   = 2'd1,
        ALU_OP_NOTB = 2'd2,
        ALU_OP_ADD  = 2'd3
    } alu_op_t;

    typedef enum logic {
        PH_IDLE = 1'b0,
        PH_MEM  = 1'b1
    } phase_t;

    typedef struct packed {
        logic [8:0] next_addr;
        logic [2:0] jam;
        logic [1:0] shift;
        logic [5:0] alu;
        logic [8:0] c_field;
        logic [2:0] mem;
        logic [3:0] b_sel;
    } microinstr_t;

    typedef struct packed {
        logic [31:0] c_bus;
        logic        n;
        logic        z;
    } alu_out_t;

    typedef struct packed {
        logic [8:0]  micro_pc;
        logic [31:0] c_bus;
        logic        n;
        logic        z;
        logic [31:0] pc;
        logic [31:0] mar;
        logic [31:0] mdr;
        logic [7:0]  mbr;
        logic [31:0] sp;
        logic [31:0] tos;
        logic [31:0] h;
    } out_item_t;

endpackage

// File: rtl/mic1_microcycle_datapath.sv
// MIC-1 data path top level: register file, sequencing, memories and result queue.
//
// Load items (control-store word, memory byte) and no-op items complete in the
// clock they are accepted; a microcycle item also has a memory phase. In the clock
// the item is accepted, the microinstruction already held in the control store's
// read register is decoded, the ALU and shifter run and the C bus is written back,
// and the fetch, word read and word write are issued to the four byte-lane
// memories. In the memory phase that follows, read data returns, MBR and MDR are
// updated, and the next micro address is formed and presented straight to the
// control store, so the next microcycle can be accepted in the following clock.
// No item is accepted in the memory phase. Results pass through a two-entry output
// queue; a full queue stalls input unless a result is popped in the same clock.
// Stores have no clearing pass; they hold undefined contents until written.
module mic1_microcycle_datapath (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] load_addr,
    input  logic [35:0] load_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [8:0]  micro_pc,
    output logic [31:0] c_bus_value,
    output logic        neg_flag,
    output logic        zero_flag,
    output logic [31:0] prog_counter,
    output logic [31:0] mem_addr_reg,
    output logic [31:0] mem_data_reg,
    output logic [7:0]  fetched_byte,
    output logic [31:0] stack_ptr,
    output logic [31:0] top_of_stack,
    output logic [31:0] holding_reg
);

    typedef struct packed {
        logic [8:0] next_addr;
        logic [2:0] jam;
        logic       fetch;
        logic       read;
        logic [1:0] pc_lane;
    } pend_t;

    // Architectural registers.
    logic [31:0] mar_reg, mdr_reg, pc_reg, sp_reg, lv_reg, cpp_reg, tos_reg, opc_reg, h_reg;
    logic [31:0] mar_next, mdr_next, pc_next, sp_next, lv_next, cpp_next, tos_next;
    logic [31:0] opc_next, h_next;
    logic [7:0]  mbr_reg, mbr_next;
    logic        n_reg, n_next, z_reg, z_next;
    logic [8:0]  micro_reg, micro_next;
    logic [31:0] c_reg, c_next;
    pend_t       pend_reg, pend_next;
    mic1_pkg::phase_t phase_reg, phase_next;

    // Output queue.
    mic1_pkg::out_item_t q0_reg, q1_reg, push_item;
    logic [1:0]  q_count_reg, q_count_next;
    logic        push, pop;

    logic        accept;
    logic        run_a;
    logic        load_cs;
    logic        load_mem;
    mic1_pkg::req_t req;

    logic [35:0]           cs_rdata;
    mic1_pkg::microinstr_t mi;
    logic [31:0]           b_bus;
    mic1_pkg::alu_out_t    alu_res;
    logic [31:0]           c_val;
    logic [31:0]           mar_c, mdr_c, pc_c;
    logic                  do_write;
    logic [31:0]           load_byte_addr;

    logic [mic1_pkg::ROW_AW-1:0] fetch_row, read_row, mwrite_row, load_row;
    logic [1:0]                  load_lane;
    logic                        lane_we    [mic1_pkg::LANES];
    logic [mic1_pkg::ROW_AW-1:0] lane_wrow  [mic1_pkg::LANES];
    logic [7:0]                  lane_wdata [mic1_pkg::LANES];
    logic [7:0]                  lane_rd_a  [mic1_pkg::LANES];
    logic [7:0]                  lane_rd_b  [mic1_pkg::LANES];
    logic [31:0]                 read_word;
    logic                        jam_hi;

    assign req      = mic1_pkg::req_t'(req_type);
    assign accept   = in_valid && in_ready;
    assign pop      = out_valid && out_ready;
    assign run_a    = accept && (req == mic1_pkg::REQ_RUN);
    assign load_cs  = accept && (req == mic1_pkg::REQ_CS_WRITE)
                      && (load_addr[15:mic1_pkg::CS_AW] == '0);
    assign load_mem = accept && (req == mic1_pkg::REQ_MEM_WRITE);

    // Control store, read every clock at the micro address the block will hold next.
    mic1_cstore u_cstore (
        .clk   (clk),
        .we    (load_cs),
        .waddr (load_addr[mic1_pkg::CS_AW-1:0]),
        .wdata (load_data),
        .raddr (micro_next),
        .rdata (cs_rdata)
    );

    assign mi = mic1_pkg::microinstr_t'(cs_rdata);

    always_comb
    begin
        unique case (mic1_pkg::bsel_t'(mi.b_sel))
            mic1_pkg::B_MDR:  b_bus = mdr_reg;
            mic1_pkg::B_PC:   b_bus = pc_reg;
            mic1_pkg::B_MBR:  b_bus = {{24{mbr_reg[7]}}, mbr_reg};
            mic1_pkg::B_MBRU: b_bus = {24'd0, mbr_reg};
            mic1_pkg::B_SP:   b_bus = sp_reg;
            mic1_pkg::B_LV:   b_bus = lv_reg;
            mic1_pkg::B_CPP:  b_bus = cpp_reg;
            mic1_pkg::B_TOS:  b_bus = tos_reg;
            mic1_pkg::B_OPC:  b_bus = opc_reg;
            default:          b_bus = 32'd0;
        endcase
    end

    mic1_alu u_alu (
        .alu_fn   (mi.alu),
        .shift_fn (mi.shift),
        .a_bus    (h_reg),
        .b_bus    (b_bus),
        .result   (alu_res)
    );

    assign c_val = alu_res.c_bus;
    assign mar_c = mi.c_field[mic1_pkg::C_MAR] ? c_val : mar_reg;
    assign mdr_c = mi.c_field[mic1_pkg::C_MDR] ? c_val : mdr_reg;
    assign pc_c  = mi.c_field[mic1_pkg::C_PC]  ? c_val : pc_reg;

    // A write together with a read is dropped; only the read is issued.
    assign do_write   = mi.mem[mic1_pkg::MEM_WRITE] && !mi.mem[mic1_pkg::MEM_READ];
    assign fetch_row  = pc_c[mic1_pkg::MEM_AW-1:2];
    assign read_row   = mar_c[mic1_pkg::ROW_AW-1:0];
    assign mwrite_row = mar_c[mic1_pkg::ROW_AW-1:0];
    assign load_byte_addr = {16'd0, load_addr};
    assign load_row   = load_byte_addr[mic1_pkg::MEM_AW-1:2];
    assign load_lane  = load_byte_addr[1:0];

    for (genvar gi = 0; gi < mic1_pkg::LANES; gi++)
    begin : g_lane
        always_comb
        begin
            lane_we[gi]    = (run_a && do_write) || (load_mem && (load_lane == 2'(gi)));
            lane_wrow[gi]  = run_a ? mwrite_row : load_row;
            lane_wdata[gi] = run_a ? mdr_c[8*gi +: 8] : load_data[7:0];
        end

        mic1_mem_lane u_lane (
            .clk     (clk),
            .we      (lane_we[gi]),
            .wrow    (lane_wrow[gi]),
            .wdata   (lane_wdata[gi]),
            .rrow_a  (fetch_row),
            .rrow_b  (read_row),
            .rdata_a (lane_rd_a[gi]),
            .rdata_b (lane_rd_b[gi])
        );
    end

    assign read_word = {lane_rd_b[3], lane_rd_b[2], lane_rd_b[1], lane_rd_b[0]};

    // Register next values.
    always_comb
    begin
        mar_next   = mar_reg;
        mdr_next   = mdr_reg;
        pc_next    = pc_reg;
        sp_next    = sp_reg;
        lv_next    = lv_reg;
        cpp_next   = cpp_reg;
        tos_next   = tos_reg;
        opc_next   = opc_reg;
        h_next     = h_reg;
        mbr_next   = mbr_reg;
        n_next     = n_reg;
        z_next     = z_reg;
        micro_next = micro_reg;
        c_next     = c_reg;
        pend_next  = pend_reg;
        jam_hi     = 1'b0;
        if (run_a)
        begin
            mar_next = mar_c;
            mdr_next = mdr_c;
            pc_next  = pc_c;
            sp_next  = mi.c_field[mic1_pkg::C_SP]  ? c_val : sp_reg;
            lv_next  = mi.c_field[mic1_pkg::C_LV]  ? c_val : lv_reg;
            cpp_next = mi.c_field[mic1_pkg::C_CPP] ? c_val : cpp_reg;
            tos_next = mi.c_field[mic1_pkg::C_TOS] ? c_val : tos_reg;
            opc_next = mi.c_field[mic1_pkg::C_OPC] ? c_val : opc_reg;
            h_next   = mi.c_field[mic1_pkg::C_H]   ? c_val : h_reg;
            n_next   = alu_res.n;
            z_next   = alu_res.z;
            c_next   = c_val;
            pend_next.next_addr = mi.next_addr;
            pend_next.jam       = mi.jam;
            pend_next.fetch     = mi.mem[mic1_pkg::MEM_FETCH];
            pend_next.read      = mi.mem[mic1_pkg::MEM_READ];
            pend_next.pc_lane   = pc_c[1:0];
        end
        if (phase_reg == mic1_pkg::PH_MEM)
        begin
            if (pend_reg.fetch)
            begin
                mbr_next = lane_rd_a[pend_reg.pc_lane];
            end
            if (pend_reg.read)
            begin
                mdr_next = read_word;
            end
            jam_hi = (pend_reg.jam[mic1_pkg::JAM_Z] && z_reg)
                     || (pend_reg.jam[mic1_pkg::JAM_N] && n_reg);
            micro_next = pend_reg.next_addr | {jam_hi, 8'd0};
            if (pend_reg.jam[mic1_pkg::JAM_C])
            begin
                micro_next = micro_next | {1'b0, mbr_next};
            end
        end
    end

    // Sequencer next state.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            mic1_pkg::PH_IDLE:
            begin
                if (run_a)
                begin
                    phase_next = mic1_pkg::PH_MEM;
                end
            end
            mic1_pkg::PH_MEM:
            begin
                phase_next = mic1_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = mic1_pkg::PH_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready = 1'b0;
        push     = 1'b0;
        unique case (phase_reg)
            mic1_pkg::PH_IDLE:
            begin
                in_ready = (q_count_reg != 2'd2) || out_ready;
                push     = in_valid && in_ready && (req != mic1_pkg::REQ_RUN);
            end
            mic1_pkg::PH_MEM:
            begin
                push = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
                push     = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        push_item.micro_pc = micro_next;
        push_item.c_bus    = (phase_reg == mic1_pkg::PH_MEM) ? c_reg : 32'd0;
        push_item.n        = n_reg;
        push_item.z        = z_reg;
        push_item.pc       = pc_reg;
        push_item.mar      = mar_reg;
        push_item.mdr      = mdr_next;
        push_item.mbr      = mbr_next;
        push_item.sp       = sp_reg;
        push_item.tos      = tos_reg;
        push_item.h        = h_reg;
    end

    assign q_count_next = q_count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mar_reg     <= 32'd0;
            mdr_reg     <= 32'd0;
            pc_reg      <= 32'd0;
            sp_reg      <= 32'd0;
            lv_reg      <= 32'd0;
            cpp_reg     <= 32'd0;
            tos_reg     <= 32'd0;
            opc_reg     <= 32'd0;
            h_reg       <= 32'd0;
            mbr_reg     <= 8'd0;
            n_reg       <= 1'b0;
            z_reg       <= 1'b1;
            micro_reg   <= 9'd0;
            phase_reg   <= mic1_pkg::PH_IDLE;
            q_count_reg <= 2'd0;
        end
        else
        begin
            mar_reg     <= mar_next;
            mdr_reg     <= mdr_next;
            pc_reg      <= pc_next;
            sp_reg      <= sp_next;
            lv_reg      <= lv_next;
            cpp_reg     <= cpp_next;
            tos_reg     <= tos_next;
            opc_reg     <= opc_next;
            h_reg       <= h_next;
            mbr_reg     <= mbr_next;
            n_reg       <= n_next;
            z_reg       <= z_next;
            micro_reg   <= micro_next;
            phase_reg   <= phase_next;
            q_count_reg <= q_count_next;
        end
    end

    // Payload registers: pending microcycle fields and queue entries.
    always_ff @(posedge clk)
    begin
        c_reg    <= c_next;
        pend_reg <= pend_next;
        if (pop)
        begin
            if (q_count_reg == 2'd2)
            begin
                q0_reg <= q1_reg;
                if (push)
                begin
                    q1_reg <= push_item;
                end
            end
            else if (push)
            begin
                q0_reg <= push_item;
            end
        end
        else if (push)
        begin
            if (q_count_reg == 2'd0)
            begin
                q0_reg <= push_item;
            end
            else
            begin
                q1_reg <= push_item;
            end
        end
    end

    assign out_valid    = (q_count_reg != 2'd0);
    assign micro_pc     = q0_reg.micro_pc;
    assign c_bus_value  = q0_reg.c_bus;
    assign neg_flag     = q0_reg.n;
    assign zero_flag    = q0_reg.z;
    assign prog_counter = q0_reg.pc;
    assign mem_addr_reg = q0_reg.mar;
    assign mem_data_reg = q0_reg.mdr;
    assign fetched_byte = q0_reg.mbr;
    assign stack_ptr    = q0_reg.sp;
    assign top_of_stack = q0_reg.tos;
    assign holding_reg  = q0_reg.h;

`ifndef ASSERT_OFF
    a_run_enters_mem: assert property (@(posedge clk) disable iff (!rst_n)
        run_a |=> (phase_reg == mic1_pkg::PH_MEM))
        else $error("microcycle item did not enter the memory phase");

    a_mem_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mic1_pkg::PH_MEM) |=> (phase_reg == mic1_pkg::PH_IDLE))
        else $error("memory phase lasted more than one clock");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((q_count_reg != 2'd2) || pop))
        else $error("result pushed into a full output queue");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count_reg != 2'd3)
        else $error("output queue count out of range");

    a_load_keeps_upc: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req != mic1_pkg::REQ_RUN)) |=> $stable(micro_reg))
        else $error("load item changed the micro address");
`endif

endmodule

// File: rtl/mic1_cstore.sv
// Control store: 36-bit microinstruction memory with write-to-read bypass.
module mic1_cstore (
    input  logic                      clk,
    input  logic                      we,
    input  logic [mic1_pkg::CS_AW-1:0] waddr,
    input  logic [35:0]               wdata,
    input  logic [mic1_pkg::CS_AW-1:0] raddr,
    output logic [35:0]               rdata
);

    logic [35:0] mem_array [mic1_pkg::CS_DEPTH];
    logic [35:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        // A word written to the entry being read is forwarded, so the read
        // register always mirrors the entry at the current micro address.
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/mic1_mem_lane.sv
// One byte lane of main memory: one write port, two read-first read ports.
module mic1_mem_lane (
    input  logic                        clk,
    input  logic                        we,
    input  logic [mic1_pkg::ROW_AW-1:0] wrow,
    input  logic [7:0]                  wdata,
    input  logic [mic1_pkg::ROW_AW-1:0] rrow_a,
    input  logic [mic1_pkg::ROW_AW-1:0] rrow_b,
    output logic [7:0]                  rdata_a,
    output logic [7:0]                  rdata_b
);

    logic [7:0] mem_array [mic1_pkg::ROWS];
    logic [7:0] rdata_a_reg;
    logic [7:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[wrow] <= wdata;
        end
        rdata_a_reg <= mem_array[rrow_a];
        rdata_b_reg <= mem_array[rrow_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// File: rtl/mic1_alu.sv
// MIC-1 ALU, shifter and N/Z flag generation.
module mic1_alu (
    input  logic [5:0]          alu_fn,
    input  logic [1:0]          shift_fn,
    input  logic [31:0]         a_bus,
    input  logic [31:0]         b_bus,
    output mic1_pkg::alu_out_t  result
);

    logic [31:0] ea;
    logic [31:0] eb;
    logic [31:0] alu_val;
    logic [31:0] sll_val;
    logic [31:0] sft_val;
    mic1_pkg::alu_op_t op;

    always_comb
    begin
        op = mic1_pkg::alu_op_t'(alu_fn[5:4]);
        ea = alu_fn[mic1_pkg::ALU_ENA] ? a_bus : 32'd0;
        eb = alu_fn[mic1_pkg::ALU_ENB] ? b_bus : 32'd0;
        if (alu_fn[mic1_pkg::ALU_INVA])
        begin
            ea = ~ea;
        end
        unique case (op)
            mic1_pkg::ALU_OP_AND:  alu_val = ea & eb;
            mic1_pkg::ALU_OP_OR:   alu_val = ea | eb;
            mic1_pkg::ALU_OP_NOTB: alu_val = ~eb;
            mic1_pkg::ALU_OP_ADD:  alu_val = ea + eb + {31'd0, alu_fn[mic1_pkg::ALU_INC]};
            default:               alu_val = 32'd0;
        endcase
        // With both shift bits set, the left shift by eight comes first.
        sll_val = shift_fn[mic1_pkg::SFT_SLL8] ? {alu_val[23:0], 8'd0} : alu_val;
        sft_val = shift_fn[mic1_pkg::SFT_SRA1] ? {sll_val[31], sll_val[31:1]} : sll_val;
        result.c_bus = sft_val;
        result.n     = alu_val[31];
        result.z     = (alu_val == 32'd0);
    end

endmodule
